>>> rtl/stereo_vu_level_meter_defines.svh
// ----------------------------------------------------------------------------
// Stereo VU level meter assertion macros
// Shared concurrent-check wrappers, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_VU_LEVEL_METER_DEFINES_SVH
`define STEREO_VU_LEVEL_METER_DEFINES_SVH

// same-cycle implication
`define SVLM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svlm check failed");

// next-cycle implication
`define SVLM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svlm check failed");

`endif

>>> rtl/svlm_pkg.sv
// ----------------------------------------------------------------------------
// svlm_pkg
// Types, constants and helpers for the stereo VU level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package svlm_pkg;

  localparam int MAX_BLOCK_FRAMES = 1024;
  localparam int LOG_TABLE_DEPTH  = 1024;   // power of two

  localparam int SAMPLE_W      = 16;
  localparam int LEVEL_W       = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int MEAN_W        = 32;
  localparam int LOG_FRAC_BITS = 20;
  localparam int WIN_W         = 8;
  localparam int HOLD_W        = 10;
  localparam int FALL_W        = 15;
  localparam int T_W           = 58;
  localparam int OUT_SHIFT     = 36;

  localparam logic [30:0]        PI2_Q30      = 31'd1686629713;
  localparam logic [25:0]        K1_Q16       = 26'd39206878;
  localparam logic signed [63:0] OFF_Q36      = -64'sd558327121378636;
  localparam logic signed [15:0] NONPOS_LEVEL = -16'sd19024;

  localparam logic signed [15:0] RST_CEILING = 16'sd120;
  localparam logic [9:0]         RST_HOLD    = 10'd50;
  localparam logic [14:0]        RST_FALL    = 15'd50;
  localparam logic signed [15:0] RST_FLOOR   = -16'sd10000;
  localparam logic [7:0]         RST_WINDOW  = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING = 3'd0,
    CFG_HOLD    = 3'd1,
    CFG_FALL    = 3'd2,
    CFG_FLOOR   = 3'd3,
    CFG_WINDOW  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOISE,
    ST_DIVB,
    ST_WAITB,
    ST_DIVN,
    ST_WAITN,
    ST_PMUL,
    ST_SUB,
    ST_NORM,
    ST_LOG,
    ST_MUL,
    ST_ADD,
    ST_LVL,
    ST_METER,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_end;
  } svlm_in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] left_level;
    logic signed [LEVEL_W-1:0] right_level;
    logic signed [LEVEL_W-1:0] left_peak;
    logic signed [LEVEL_W-1:0] right_peak;
    logic                      block_overflow;
  } svlm_out_t;

  typedef struct packed {
    logic acc;
    logic noise_upd;
    logic div_start;
    logic div_sel;     // 0: block mean, 1: noise mean
    logic load_mb;
    logic load_mn;
    logic p_mul;
    logic sub;
    logic norm_step;
    logic log_init;
    logic log_step;
    logic mul_fin;
    logic add_fin;
    logic lvl_load;
    logic meter_upd;
    logic out_load;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic nonpos;
    logic a_msb;
  } sts_t;

  function automatic logic [SAMPLE_W-1:0] abs16(input logic [SAMPLE_W-1:0] s);
    return s[SAMPLE_W-1] ? (SAMPLE_W'(0) - s) : s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/stereo_vu_level_meter.sv
// A frame without block_end is accepted whenever the meter is idle; a block_end
// frame yields its result once the block-end computation is through, which is
// set by the shared serial divider (four divisions), the normalize and the
// log2; a stalled out_ready adds to that.
// Throughput: one frame per cycle between block ends; intake pauses during
// the block-end computation. Async low reset clears sums, meters; presets config.
// ----------------------------------------------------------------------------
// stereo_vu_level_meter
// Stereo block level meter with noise floor, peak hold and step falloff.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_vu_level_meter_defines.svh"

module stereo_vu_level_meter import svlm_pkg::*; #(
  parameter int MaxBlockFrames = MAX_BLOCK_FRAMES,
  parameter int LogTableDepth  = LOG_TABLE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire svlm_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output svlm_out_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  svlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .block_end_i (in_data_i.block_end),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  svlm_dp #(
    .MaxBlockFrames (MaxBlockFrames),
    .LogTableDepth  (LogTableDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  `SVLM_ASSERT_IMPL(a_idle_div_quiet, in_ready_o, !sts.div_busy)
  `SVLM_ASSERT_NEXT(a_load_gives_valid, cmd.out_load, out_valid_o)
  `SVLM_ASSERT_IMPL(a_cmd_exclusive, 1'b1, $onehot0({cmd.acc, cmd.noise_upd, cmd.div_start, cmd.meter_upd, cmd.out_load}))

endmodule

`default_nettype wire

>>> rtl/svlm_div.sv
// ----------------------------------------------------------------------------
// svlm_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module svlm_div import svlm_pkg::*; #(
  parameter int DvdW = 50,
  parameter int DvsW = 19
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DvdW-1:0]      quotient_o
);

  localparam int CntW = $clog2(DvdW + 1);

  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DvsW:0]   shifted;
  logic [DvsW+1:0] diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[DvdW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DvsW+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DvdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
      quo_d = {quo_q[DvdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/svlm_ctrl.sv
// ----------------------------------------------------------------------------
// svlm_ctrl
// Sequencer: frame intake, per-channel level computation, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module svlm_ctrl import svlm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic block_end_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam int LogCntW = $clog2(LOG_FRAC_BITS);

  state_e               state_q, state_d;
  logic                 ch_q, ch_d;
  logic [LogCntW-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i && block_end_i) state_d = ST_NOISE;
      ST_NOISE: state_d = ST_DIVB;
      ST_DIVB:  state_d = ST_WAITB;
      ST_WAITB: if (sts_i.div_done) state_d = ST_DIVN;
      ST_DIVN:  state_d = ST_WAITN;
      ST_WAITN: if (sts_i.div_done) state_d = ST_PMUL;
      ST_PMUL:  state_d = ST_SUB;
      ST_SUB:   state_d = sts_i.nonpos ? ST_LVL : ST_NORM;
      ST_NORM:  if (sts_i.a_msb) state_d = ST_LOG;
      ST_LOG:   if (cnt_q == LogCntW'(LOG_FRAC_BITS - 1)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_LVL;
      ST_LVL:   state_d = ST_METER;
      ST_METER: state_d = ch_q ? ST_OUT : ST_DIVB;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.ch   = ch_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
      end
      ST_NOISE: cmd_o.noise_upd = 1'b1;
      ST_DIVB:  cmd_o.div_start = 1'b1;
      ST_WAITB: cmd_o.load_mb   = sts_i.div_done;
      ST_DIVN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
      end
      ST_WAITN: cmd_o.load_mn   = sts_i.div_done;
      ST_PMUL:  cmd_o.p_mul     = 1'b1;
      ST_SUB:   cmd_o.sub       = 1'b1;
      ST_NORM: begin
        cmd_o.log_init  = sts_i.a_msb;
        cmd_o.norm_step = ~sts_i.a_msb;
      end
      ST_LOG:   cmd_o.log_step  = 1'b1;
      ST_MUL:   cmd_o.mul_fin   = 1'b1;
      ST_ADD:   cmd_o.add_fin   = 1'b1;
      ST_LVL:   cmd_o.lvl_load  = 1'b1;
      ST_METER: cmd_o.meter_upd = 1'b1;
      ST_OUT:   cmd_o.out_load  = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_o.meter_upd) ch_d = 1'b1;
    if (cmd_o.out_load) begin
      ch_d        = 1'b0;
      out_valid_d = 1'b1;
    end
    if (cmd_o.log_init) cnt_d = '0;
    else if (cmd_o.log_step) cnt_d = cnt_q + LogCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/svlm_dp.sv
// ----------------------------------------------------------------------------
// svlm_dp
// Datapath: block and noise sums, mean division, log2, level map, meters.
// ----------------------------------------------------------------------------
`default_nettype none

module svlm_dp import svlm_pkg::*; #(
  parameter int MaxBlockFrames = MAX_BLOCK_FRAMES,
  parameter int LogTableDepth  = LOG_TABLE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire svlm_in_t              in_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  output svlm_out_t                  out_data_o
);

  localparam int CntW   = $clog2(MaxBlockFrames + 1);
  localparam int BsumW  = $clog2(MaxBlockFrames) + SAMPLE_W;
  localparam int NsumW  = BsumW + WIN_W;
  localparam int NcntW  = CntW + WIN_W;
  localparam int DvdW   = NsumW + 16;
  localparam int IdxW   = $clog2(LogTableDepth);
  localparam int PrdW   = 54;

  // configuration
  logic signed [LEVEL_W-1:0] ceil_q, floor_q;
  logic [HOLD_W-1:0]         hold_q;
  logic [FALL_W-1:0]         fall_q;
  logic [WIN_W-1:0]          win_q;

  // accumulation state
  logic [BsumW-1:0] bsum_q [2];
  logic [CntW-1:0]  bcnt_q;
  logic             ovf_q;
  logic [NsumW-1:0] nsum_q [2];
  logic [NcntW-1:0] ncnt_q;
  logic [WIN_W-1:0] bctr_q;

  // meters
  logic signed [LEVEL_W-1:0] cur_q [2];
  logic signed [LEVEL_W-1:0] peak_q [2];
  logic [HOLD_W-1:0]         age_q [2];

  // level pipeline
  logic [MEAN_W-1:0]         mb_q, mn_q, p_q, a_q;
  logic [4:0]                e_q;
  logic                      nonpos_q;
  logic [30:0]               m_q;
  logic [LOG_FRAC_BITS-1:0]  r_q;
  logic signed [PrdW-1:0]    prod_q;
  logic signed [T_W-1:0]     t_q;
  logic signed [LEVEL_W-1:0] lvl_q;
  svlm_out_t                 res_q;

  // divider
  logic [DvdW-1:0]  div_dvd, div_quo;
  logic [NcntW-1:0] div_dvs;
  logic             div_busy, div_done;

  assign div_dvd = cmd_i.div_sel ? {nsum_q[cmd_i.ch], 16'h0000}
                                 : {DvdW'(bsum_q[cmd_i.ch]) << 16};
  assign div_dvs = cmd_i.div_sel ? ncnt_q : NcntW'(bcnt_q);

  svlm_div #(
    .DvdW (DvdW),
    .DvsW (NcntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign sts_o.div_done = div_done;
  assign sts_o.div_busy = div_busy;
  assign sts_o.nonpos   = (p_q <= mn_q);
  assign sts_o.a_msb    = a_q[MEAN_W-1];

  // ---- combinational helpers ----
  logic [SAMPLE_W-1:0] abs_l, abs_r;
  logic                room;
  logic                win_clr;
  logic [62:0]         pprod;
  logic [61:0]         sq;
  logic [31:0]         sq_hi;
  logic [30:0]         frac_keep;
  logic signed [6:0]   e_rel;
  logic signed [26:0]  l2;
  logic signed [T_W-1:0] t_sum;
  logic signed [T_W-1:0] t_adj;
  logic signed [LEVEL_W-1:0] lvl_n;

  assign abs_l   = abs16(in_data_i.left_sample);
  assign abs_r   = abs16(in_data_i.right_sample);
  assign room    = (bcnt_q < CntW'(MaxBlockFrames));
  assign win_clr = (bctr_q >= win_q);
  assign pprod   = {32'd0, PI2_Q30} * {31'd0, mb_q};
  assign sq      = {31'd0, m_q} * {31'd0, m_q};
  assign sq_hi   = sq[61:30];
  // keep the top IdxW fraction bits of the mantissa, IdxW as set by LogTableDepth
  assign frac_keep = (a_q[30:0] >> (31 - IdxW)) << (31 - IdxW);
  assign e_rel   = $signed({2'b00, e_q}) - 7'sd16;
  assign l2      = $signed({e_rel, r_q});
  assign t_sum   = T_W'(prod_q) + OFF_Q36[T_W-1:0];
  // truncate toward zero
  assign t_adj   = t_q[T_W-1] ? (t_q + T_W'((64'd1 << OUT_SHIFT) - 64'd1)) : t_q;
  assign lvl_n   = nonpos_q ? NONPOS_LEVEL : LEVEL_W'(t_adj >>> OUT_SHIFT);

  // meter update for the selected channel
  logic signed [LEVEL_W-1:0] m_cur, m_pk, v_clamp, pk1, pk2, cur_n, cur_f;
  logic [HOLD_W-1:0]         age1, age3;
  logic [HOLD_W:0]           age2;
  logic signed [LEVEL_W+1:0] gap, drop;

  always_comb begin
    m_cur   = cur_q[cmd_i.ch];
    m_pk    = peak_q[cmd_i.ch];
    v_clamp = (lvl_q > ceil_q) ? ceil_q : lvl_q;
    pk1     = m_pk;
    age1    = age_q[cmd_i.ch];
    if (lvl_q > m_pk) begin
      pk1  = v_clamp;
      age1 = '0;
    end
    age2 = {1'b0, age1} + (HOLD_W+1)'(1);
    if (age2 >= {1'b0, hold_q}) begin
      pk2  = m_cur;
      age3 = '0;
    end else begin
      pk2  = pk1;
      age3 = age2[HOLD_W-1:0];
    end
    gap   = (LEVEL_W+2)'(m_cur) - (LEVEL_W+2)'(lvl_q);
    drop  = (LEVEL_W+2)'(m_cur) - $signed({3'b000, fall_q});
    cur_f = (gap > $signed({3'b000, fall_q})) ? LEVEL_W'(drop) : lvl_q;
    if (lvl_q > m_cur) cur_n = v_clamp;
    else cur_n = (cur_f < floor_q) ? floor_q : cur_f;
  end

  // ---- control-side registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q  <= RST_CEILING;
      hold_q  <= RST_HOLD;
      fall_q  <= RST_FALL;
      floor_q <= RST_FLOOR;
      win_q   <= RST_WINDOW;
      bsum_q  <= '{default: '0};
      bcnt_q  <= '0;
      ovf_q   <= 1'b0;
      nsum_q  <= '{default: '0};
      ncnt_q  <= '0;
      bctr_q  <= '0;
      cur_q   <= '{default: '0};
      peak_q  <= '{default: '0};
      age_q   <= '{default: '0};
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CEILING: ceil_q  <= cfg_data_i;
          CFG_HOLD:    hold_q  <= cfg_data_i[HOLD_W-1:0];
          CFG_FALL:    fall_q  <= cfg_data_i[FALL_W-1:0];
          CFG_FLOOR:   floor_q <= cfg_data_i;
          CFG_WINDOW:  win_q   <= cfg_data_i[WIN_W-1:0];
          default:     ;
        endcase
      end
      if (cmd_i.acc) begin
        if (room) begin
          bsum_q[0] <= bsum_q[0] + BsumW'(abs_l);
          bsum_q[1] <= bsum_q[1] + BsumW'(abs_r);
          bcnt_q    <= bcnt_q + CntW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.noise_upd) begin
        if (win_clr) begin
          bctr_q    <= '0;
          nsum_q[0] <= NsumW'(bsum_q[0]);
          nsum_q[1] <= NsumW'(bsum_q[1]);
          ncnt_q    <= NcntW'(bcnt_q);
        end else begin
          bctr_q    <= bctr_q + WIN_W'(1);
          nsum_q[0] <= nsum_q[0] + NsumW'(bsum_q[0]);
          nsum_q[1] <= nsum_q[1] + NsumW'(bsum_q[1]);
          ncnt_q    <= ncnt_q + NcntW'(bcnt_q);
        end
      end
      if (cmd_i.meter_upd) begin
        cur_q[cmd_i.ch]  <= cur_n;
        peak_q[cmd_i.ch] <= pk2;
        age_q[cmd_i.ch]  <= age3;
      end
      if (cmd_i.out_load) begin
        bsum_q <= '{default: '0};
        bcnt_q <= '0;
        ovf_q  <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mb) mb_q <= div_quo[MEAN_W-1:0];
    if (cmd_i.load_mn) mn_q <= div_quo[MEAN_W-1:0];
    if (cmd_i.p_mul)   p_q  <= pprod[61:30];
    if (cmd_i.sub) begin
      a_q      <= p_q - mn_q;
      e_q      <= 5'd31;
      nonpos_q <= (p_q <= mn_q);
    end
    if (cmd_i.norm_step) begin
      a_q <= {a_q[MEAN_W-2:0], 1'b0};
      e_q <= e_q - 5'd1;
    end
    if (cmd_i.log_init) begin
      m_q <= {1'b1, frac_keep[30:1]};
      r_q <= '0;
    end
    if (cmd_i.log_step) begin
      m_q <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
      r_q <= {r_q[LOG_FRAC_BITS-2:0], sq_hi[31]};
    end
    if (cmd_i.mul_fin)  prod_q <= $signed({28'd0, K1_Q16}) * PrdW'(l2);
    if (cmd_i.add_fin)  t_q    <= t_sum;
    if (cmd_i.lvl_load) lvl_q  <= lvl_n;
    if (cmd_i.out_load) begin
      res_q.left_level     <= cur_q[0];
      res_q.right_level    <= cur_q[1];
      res_q.left_peak      <= peak_q[0];
      res_q.right_peak     <= peak_q[1];
      res_q.block_overflow <= ovf_q;
    end
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire
